[hdl/seoa_pkg.sv]
// Shared constants and types for the spin energy and overlap accumulator.
package seoa_pkg;

	localparam int MAX_SITES  = 65536;
	localparam int NUM_PAIRS  = 32;
	localparam int PAIR_W     = 5;
	localparam int ENERGY_W   = 19;
	localparam int OVERLAP_W  = 18;
	localparam int WORD_W     = 64;
	localparam int IN_DATA_W  = 7 * WORD_W;
	localparam int OUT_DATA_W = 64;

	// saturation bounds, one bit wider than the accumulators
	localparam logic signed [ENERGY_W:0]  ENERGY_BOUND  = (ENERGY_W + 1)'(3 * MAX_SITES);
	localparam logic signed [OVERLAP_W:0] OVERLAP_BOUND = (OVERLAP_W + 1)'(MAX_SITES);

	localparam logic [PAIR_W-1:0] LAST_PAIR = PAIR_W'(NUM_PAIRS - 1);

	typedef struct packed {
		logic upd;    // accepted site: accumulate
		logic load;   // last site: copy into the drain chain and clear
		logic shift;  // output transfer: drain chain moves one cell down
	} cell_ctrl_t;

	typedef struct packed {
		logic signed [OVERLAP_W-1:0] overlap;
		logic signed [ENERGY_W-1:0]  energy_odd;
		logic signed [ENERGY_W-1:0]  energy_even;
	} pair_result_t;

endpackage

[hdl/seoa_cell.sv]
// One replica-pair cell: two energy planes, one overlap sum and a drain stage.
module seoa_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  seoa_pkg::cell_ctrl_t   ctrl,
	input  logic [2:0]            edge_even,
	input  logic [2:0]            edge_odd,
	input  logic                  pair_diff,
	input  seoa_pkg::pair_result_t drain_in,
	output seoa_pkg::pair_result_t drain_out
);
	import seoa_pkg::*;

	logic signed [ENERGY_W-1:0]  even_q;
	logic signed [ENERGY_W-1:0]  odd_q;
	logic signed [OVERLAP_W-1:0] ovl_q;
	pair_result_t                drain_q;
	pair_result_t                next_sums;

	function automatic logic signed [ENERGY_W-1:0] energy_next(
		input logic signed [ENERGY_W-1:0] acc,
		input logic [2:0]                 edges
	);
		logic [1:0]                cnt;
		logic signed [ENERGY_W:0]  sum;
		logic signed [ENERGY_W:0]  res;
		begin
			cnt = 2'({1'b0, edges[0]} + {1'b0, edges[1]} + {1'b0, edges[2]});
			// +1 per frustrated edge, -1 otherwise: 2*count - 3
			sum = {acc[ENERGY_W-1], acc} + $signed({(ENERGY_W-2)'(0), cnt, 1'b0})
				- (ENERGY_W + 1)'(3);
			if (sum > ENERGY_BOUND)
				res = ENERGY_BOUND;
			else if (sum < -ENERGY_BOUND)
				res = -ENERGY_BOUND;
			else
				res = sum;
			energy_next = res[ENERGY_W-1:0];
		end
	endfunction

	function automatic logic signed [OVERLAP_W-1:0] overlap_next(
		input logic signed [OVERLAP_W-1:0] acc,
		input logic                        diff
	);
		logic signed [OVERLAP_W:0] sum;
		logic signed [OVERLAP_W:0] res;
		begin
			sum = {acc[OVERLAP_W-1], acc} + (diff ? (OVERLAP_W + 1)'(1) : {(OVERLAP_W + 1){1'b1}});
			if (sum > OVERLAP_BOUND)
				res = OVERLAP_BOUND;
			else if (sum < -OVERLAP_BOUND)
				res = -OVERLAP_BOUND;
			else
				res = sum;
			overlap_next = res[OVERLAP_W-1:0];
		end
	endfunction

	always_comb begin
		next_sums.energy_even = energy_next(even_q, edge_even);
		next_sums.energy_odd  = energy_next(odd_q, edge_odd);
		next_sums.overlap     = overlap_next(ovl_q, pair_diff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			even_q <= '0;
			odd_q  <= '0;
			ovl_q  <= '0;
		end else if (ctrl.upd) begin
			if (ctrl.load) begin
				even_q <= '0;
				odd_q  <= '0;
				ovl_q  <= '0;
			end else begin
				even_q <= next_sums.energy_even;
				odd_q  <= next_sums.energy_odd;
				ovl_q  <= next_sums.overlap;
			end
		end
	end

	// drain stage holds the snapshot of the finished pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			drain_q <= '0;
		else if (ctrl.load)
			drain_q <= next_sums;
		else if (ctrl.shift)
			drain_q <= drain_in;
	end

	assign drain_out = drain_q;

endmodule

[hdl/spin_energy_overlap_accumulator_core.sv]
// Top level of the spin energy and overlap accumulator: cell row and stream control.
//
// One lattice site is taken per clock cycle; every pair cell updates its two energy planes
// and its overlap sum in the cycle of the transfer, so the rate is one site per cycle for as
// long as the sites stream. The site marked tlast is accumulated, then its totals are copied
// into a drain chain running through the same cells and the accumulators clear at once, so
// the next pass may start in the following cycle. The drain chain presents 32 results, one
// per output transfer, pair 0 first, tlast on pair 31. A further last site is held off
// (s_axis_tready low) until the previous burst has fully drained; ordinary sites are not.
module spin_energy_overlap_accumulator_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// site_spins, neighbor_x_spins, neighbor_y_spins, neighbor_z_spins,
	// coupling_x, coupling_y, coupling_z (64 bits each, from the lowest bit up)
	input  logic [seoa_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	input  logic                                s_axis_tlast,   // last_site
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// pair_index[4:0], energy_even[23:5], energy_odd[42:24], overlap_sum[60:43], zero pad
	output logic [seoa_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	output logic                                m_axis_tlast    // last_result
);
	import seoa_pkg::*;

	logic [WORD_W-1:0] site;
	logic [WORD_W-1:0] edges_x;
	logic [WORD_W-1:0] edges_y;
	logic [WORD_W-1:0] edges_z;
	logic [WORD_W-1:0] pair_xor;
	logic              in_xfer;
	logic              out_xfer;
	logic              busy_q;
	logic [PAIR_W-1:0] idx_q;
	cell_ctrl_t        ctrl;
	pair_result_t      chain [NUM_PAIRS+1];

	assign site     = s_axis_tdata[WORD_W-1:0];
	assign edges_x  = s_axis_tdata[4*WORD_W +: WORD_W] ^ site ^ s_axis_tdata[1*WORD_W +: WORD_W];
	assign edges_y  = s_axis_tdata[5*WORD_W +: WORD_W] ^ site ^ s_axis_tdata[2*WORD_W +: WORD_W];
	assign edges_z  = s_axis_tdata[6*WORD_W +: WORD_W] ^ site ^ s_axis_tdata[3*WORD_W +: WORD_W];
	assign pair_xor = site ^ (site >> 1);

	assign s_axis_tready = !(s_axis_tlast && busy_q);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_xfer      = m_axis_tvalid && m_axis_tready;

	always_comb begin
		ctrl.upd   = in_xfer;
		ctrl.load  = in_xfer && s_axis_tlast;
		ctrl.shift = out_xfer;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (ctrl.load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (out_xfer) begin
			if (idx_q == LAST_PAIR)
				busy_q <= 1'b0;
			idx_q <= idx_q + PAIR_W'(1);
		end
	end

	assign chain[NUM_PAIRS] = '0;

	for (genvar k = 0; k < NUM_PAIRS; k++) begin : g_cell
		seoa_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.edge_even ({edges_z[2*k], edges_y[2*k], edges_x[2*k]}),
			.edge_odd  ({edges_z[2*k+1], edges_y[2*k+1], edges_x[2*k+1]}),
			.pair_diff (pair_xor[2*k]),
			.drain_in  (chain[k+1]),
			.drain_out (chain[k])
		);
	end

	assign m_axis_tvalid = busy_q;
	assign m_axis_tlast  = (idx_q == LAST_PAIR);
	assign m_axis_tdata  = {
		(OUT_DATA_W - PAIR_W - 2*ENERGY_W - OVERLAP_W)'(0),
		chain[0].overlap,
		chain[0].energy_odd,
		chain[0].energy_even,
		idx_q
	};

endmodule

[hdl/seoa_checker.sv]
// Port-level checks of the accumulator's result bursts, bound to the top level.
module seoa_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            s_axis_tlast,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [seoa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic                            m_axis_tlast
);
	import seoa_pkg::*;

	// burst closes on the final pair
	a_last_on_final_pair: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[PAIR_W-1:0] == LAST_PAIR)
		else $error("tlast on a pair other than the final one");

	// within a burst results follow without gaps, pair numbers rising by one
	a_burst_continues: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
		m_axis_tvalid &&
		m_axis_tdata[PAIR_W-1:0] == $past(m_axis_tdata[PAIR_W-1:0]) + PAIR_W'(1))
		else $error("burst broken or pair number skipped");

	// a last site opens a burst at pair 0 in the next cycle
	a_burst_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=>
		m_axis_tvalid && m_axis_tdata[PAIR_W-1:0] == '0)
		else $error("burst did not start at pair 0");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

bind spin_energy_overlap_accumulator_core seoa_checker u_seoa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
